[hdl/top_k_area_tracker_unit_assert.svh]
// Assertion macros for the top level of the top-k area tracker.
`ifndef TOP_K_AREA_TRACKER_UNIT_ASSERT_SVH
`define TOP_K_AREA_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TKAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define TKAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TKAT_ASSERT(lbl, clk, rstn, prop, msg)
`define TKAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hdl/tkat_pkg.sv]
// Shared widths, defaults and control types for the top-k area tracker.
`timescale 1ns / 1ps
package tkat_pkg;
  localparam int unsigned AREA_W          = 26;
  localparam int unsigned INDEX_W         = 16;
  localparam int unsigned RANK_W          = 6;
  localparam int unsigned TRACKED_DEFAULT = 8;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the request presented this cycle
    logic first;  // treat all slots as cleared before insertion
    logic rot;    // rotate the chain one place towards rank 0
  } tkat_ctrl_t;
endpackage

[hdl/top_k_area_tracker_unit.sv]
// Top level of the top-k area tracker: cell chain, emission control, output register.
`timescale 1ns / 1ps
// Keeps the TRACKED_COUNT largest signed areas (twice the area) with their
// region indices, sorted high to low in a chain of cells. An ordinary
// request is inserted on acceptance; requests can arrive back to back
// while in_stall_o is low. A request with last set is inserted, then
// the chain rotates one place per cycle, unless the output side stalls,
// through cell 0 into the output register, giving TRACKED_COUNT results
// in rank order; in_stall_o stays high until the last one is loaded.
// After a full turn the chain holds its contents again. Ties keep arrival
// order; zero and negative areas are never kept. Reset empties all slots.
module top_k_area_tracker_unit import tkat_pkg::*; #(
  parameter int unsigned TRACKED_COUNT = TRACKED_DEFAULT  // 1 to 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [AREA_W-1:0]  area2_i,
  input  logic [INDEX_W-1:0]        region_index_i,
  input  logic                      first_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [RANK_W-1:0]         rank_o,
  output logic signed [AREA_W-1:0]  kept_area2_o,
  output logic [INDEX_W-1:0]        kept_index_o,
  output logic                      final_slot_o
);
`include "top_k_area_tracker_unit_assert.svh"

  localparam int unsigned CW = (TRACKED_COUNT > 1) ? $clog2(TRACKED_COUNT) : 1;

  tkat_ctrl_t               ctrl;
  logic                     in_acc, rot;
  logic                     busy_q, busy_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     out_valid_q;
  logic [RANK_W-1:0]        rank_q;
  logic signed [AREA_W-1:0] area_out_q;
  logic [INDEX_W-1:0]       index_out_q;
  logic                     final_q;
  logic                     last_rot;

  logic                     take  [TRACKED_COUNT];
  logic signed [AREA_W-1:0] c_area[TRACKED_COUNT];
  logic [INDEX_W-1:0]       c_idx [TRACKED_COUNT];

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  // rotate when the output register is free or being drained
  assign rot        = busy_q && (!out_valid_q || !out_stall_i);
  assign last_rot   = (cnt_q == CW'(TRACKED_COUNT - 1));

  assign ctrl.ins   = in_acc;
  assign ctrl.first = first_i;
  assign ctrl.rot   = rot;

  for (genvar g = 0; g < TRACKED_COUNT; g++) begin : g_cell
    localparam int unsigned PREV = (g == 0) ? 0 : g - 1;
    localparam int unsigned NEXT = (g == TRACKED_COUNT - 1) ? 0 : g + 1;
    tkat_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_area_i   (area2_i),
      .new_index_i  (region_index_i),
      .prev_take_i  ((g == 0) ? 1'b0 : take[PREV]),
      .prev_area_i  (c_area[PREV]),
      .prev_index_i (c_idx[PREV]),
      .next_area_i  (c_area[NEXT]),
      .next_index_i (c_idx[NEXT]),
      .take_o       (take[g]),
      .area_o       (c_area[g]),
      .index_o      (c_idx[g])
    );
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (in_acc && last_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (rot) begin
      cnt_d = cnt_q + 1'b1;
      if (last_rot) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (rot) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded from cell 0 as the chain turns
  always_ff @(posedge clk_i) begin
    if (rot) begin
      rank_q      <= RANK_W'(cnt_q);
      area_out_q  <= c_area[0];
      index_out_q <= c_idx[0];
      final_q     <= last_rot;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rank_o       = rank_q;
  assign kept_area2_o = area_out_q;
  assign kept_index_o = index_out_q;
  assign final_slot_o = final_q;

  `TKAT_ASSERT_NEXT(a_last_starts_emit, clk_i, rst_ni, in_acc && last_i, busy_q, "last request did not start emission")
  `TKAT_ASSERT(a_emit_ends_on_final, clk_i, rst_ni, $fell(busy_q) |-> (out_valid_o && final_slot_o), "emission ended without final slot")
  `TKAT_ASSERT_NEXT(a_rank_steps, clk_i, rst_ni, out_valid_o && !out_stall_i && !final_slot_o, out_valid_o && (rank_o == RANK_W'($past(rank_o) + 1'b1)), "rank sequence broken")
endmodule

[hdl/tkat_cell.sv]
// One slot of the sorted chain: compare, take, shift down or rotate up.
`timescale 1ns / 1ps
module tkat_cell import tkat_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tkat_ctrl_t                ctrl_i,
  input  logic signed [AREA_W-1:0]  new_area_i,
  input  logic [INDEX_W-1:0]        new_index_i,
  input  logic                      prev_take_i,
  input  logic signed [AREA_W-1:0]  prev_area_i,
  input  logic [INDEX_W-1:0]        prev_index_i,
  input  logic signed [AREA_W-1:0]  next_area_i,
  input  logic [INDEX_W-1:0]        next_index_i,
  output logic                      take_o,
  output logic signed [AREA_W-1:0]  area_o,
  output logic [INDEX_W-1:0]        index_o
);
  logic signed [AREA_W-1:0] area_q, area_d, own_eff;
  logic [INDEX_W-1:0]       index_q, index_d;

  // a first request sees every slot as empty
  assign own_eff = ctrl_i.first ? '0 : area_q;
  assign take_o  = (own_eff < new_area_i);

  always_comb begin
    area_d  = area_q;
    index_d = index_q;
    if (ctrl_i.ins) begin
      if (prev_take_i) begin
        area_d  = ctrl_i.first ? '0 : prev_area_i;
        index_d = ctrl_i.first ? '0 : prev_index_i;
      end else if (take_o) begin
        area_d  = new_area_i;
        index_d = new_index_i;
      end else if (ctrl_i.first) begin
        area_d  = '0;
        index_d = '0;
      end
    end else if (ctrl_i.rot) begin
      area_d  = next_area_i;
      index_d = next_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q  <= '0;
      index_q <= '0;
    end else begin
      area_q  <= area_d;
      index_q <= index_d;
    end
  end

  assign area_o  = area_q;
  assign index_o = index_q;
endmodule
